/* rtl/ofp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_pkg
// shared types, constants and functions of the orthographic projection block
// ----------------------------------------------------------------------------
package ofp_pkg;

	localparam int CORDIC_STAGES_DEF = 24;
	localparam int LANE_W            = 34;
	localparam int Z_W               = 32;

	localparam logic signed [LANE_W-1:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic signed [63:0]       Q30_ONE     = 64'sd1073741824;
	localparam logic signed [63:0]       XY_LIMIT    = 64'sd2048000000;
	localparam logic [22:0]              RADIUS_RST  = 23'd6366707;

	localparam logic [1:0] REG_REF_LAT = 2'd0;
	localparam logic [1:0] REG_REF_LON = 2'd1;
	localparam logic [1:0] REG_REF_ALT = 2'd2;
	localparam logic [1:0] REG_RADIUS  = 2'd3;

	typedef struct packed {
		logic signed [LANE_W-1:0] x;
		logic signed [LANE_W-1:0] y;
		logic signed [Z_W-1:0]    z;
		logic [1:0]               quad;
	} ofp_lane_t;

	function automatic logic signed [Z_W-1:0] atan_turn(input int i);
		logic signed [Z_W-1:0] r;
		case (i)
			0: r = 32'sd536870912;
			1: r = 32'sd316933406;
			2: r = 32'sd167458907;
			3: r = 32'sd85004756;
			4: r = 32'sd42667331;
			5: r = 32'sd21354465;
			6: r = 32'sd10679838;
			7: r = 32'sd5340245;
			8: r = 32'sd2670163;
			9: r = 32'sd1335087;
			10: r = 32'sd667544;
			11: r = 32'sd333772;
			12: r = 32'sd166886;
			13: r = 32'sd83443;
			14: r = 32'sd41722;
			15: r = 32'sd20861;
			16: r = 32'sd10430;
			17: r = 32'sd5215;
			18: r = 32'sd2608;
			19: r = 32'sd1304;
			20: r = 32'sd652;
			21: r = 32'sd326;
			22: r = 32'sd163;
			23: r = 32'sd81;
			24: r = 32'sd41;
			25: r = 32'sd20;
			26: r = 32'sd10;
			27: r = 32'sd5;
			28: r = 32'sd3;
			29: r = 32'sd1;
			30: r = 32'sd1;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	function automatic logic signed [63:0] clamp64(input logic signed [63:0] v,
			input logic signed [63:0] lim);
		logic signed [63:0] r;
		if (v > lim)
			r = lim;
		else if (v < -lim)
			r = -lim;
		else
			r = v;
		return r;
	endfunction

endpackage

/* rtl/ofp_cordic_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_cordic_cell
// one rotation-mode cordic micro-rotation, registered toward the next cell
// ----------------------------------------------------------------------------
module ofp_cordic_cell #(
	parameter int STAGE = 0
) (
	input  logic              clk,
	input  ofp_pkg::ofp_lane_t d,
	output ofp_pkg::ofp_lane_t q
);
	import ofp_pkg::*;

	localparam logic signed [Z_W-1:0] ATAN = atan_turn(STAGE);

	logic signed [LANE_W-1:0] dx;
	logic signed [LANE_W-1:0] dy;
	ofp_lane_t                nxt;

	always_comb begin
		dx       = d.y >>> STAGE;
		dy       = d.x >>> STAGE;
		nxt.quad = d.quad;
		if (d.z >= 0) begin
			nxt.x = d.x - dx;
			nxt.y = d.y + dy;
			nxt.z = d.z - ATAN;
		end else begin
			nxt.x = d.x + dx;
			nxt.y = d.y - dy;
			nxt.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk) begin
		q <= nxt;
	end
endmodule

/* rtl/ofp_post.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ofp_post
// quadrant mapping, visibility test and scaling into plane coordinates
// ----------------------------------------------------------------------------
module ofp_post (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_vld,
	input  logic signed [26:0]  in_hz,
	input  ofp_pkg::ofp_lane_t  lat_l,
	input  ofp_pkg::ofp_lane_t  ref_l,
	input  ofp_pkg::ofp_lane_t  dl_l,
	input  logic [22:0]         radius,
	output logic                done,
	output logic signed [31:0]  east_x,
	output logic signed [31:0]  north_y,
	output logic signed [26:0]  height_z,
	output logic                visible
);
	import ofp_pkg::*;

	function automatic logic signed [63:0] map_c(input ofp_lane_t l);
		logic signed [63:0] c;
		case (l.quad)
			2'd0: c = 64'(l.x);
			2'd1: c = -64'(l.y);
			2'd2: c = -64'(l.x);
			default: c = 64'(l.y);
		endcase
		return clamp64(c, Q30_ONE);
	endfunction

	function automatic logic signed [63:0] map_s(input ofp_lane_t l);
		logic signed [63:0] s;
		case (l.quad)
			2'd0: s = 64'(l.y);
			2'd1: s = 64'(l.x);
			2'd2: s = -64'(l.y);
			default: s = -64'(l.x);
		endcase
		return clamp64(s, Q30_ONE);
	endfunction

	localparam logic signed [63:0] HALF30 = 64'sh2000_0000;
	localparam logic signed [63:0] HALF22 = 64'sh0020_0000;

	logic [6:1] vld;
	logic signed [26:0] hz_s1, hz_s2, hz_s3, hz_s4, hz_s5, hz_s6;

	logic signed [31:0] cl_s1, sl_s1, cr_s1, sr_s1, cd_s1, sd_s1;
	logic signed [63:0] clcd_m_s2, clsd_m_s2, srsl_s2, crsl_s2;
	logic signed [31:0] cr_s2, sr_s2;
	logic signed [31:0] clcd_s3, px_s3, cr_s3, sr_s3;
	logic signed [63:0] srsl_s3, crsl_s3;
	logic signed [63:0] crc_s4, src_s4, rpx_s4, srsl_s4, crsl_s4;
	logic               vis_s5, vis_s6;
	logic signed [32:0] py_s5;
	logic signed [31:0] ex_s5, ex_s6;
	logic signed [63:0] rpy_s6;
	logic signed [24:0] rad;

	assign rad = $signed({2'b00, radius});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld  <= '0;
			done <= 1'b0;
		end else begin
			vld  <= {vld[5:1], in_vld};
			done <= vld[6];
		end
	end

	always_ff @(posedge clk) begin
		hz_s1 <= in_hz;
		cl_s1 <= 32'(map_c(lat_l));
		sl_s1 <= 32'(map_s(lat_l));
		cr_s1 <= 32'(map_c(ref_l));
		sr_s1 <= 32'(map_s(ref_l));
		cd_s1 <= 32'(map_c(dl_l));
		sd_s1 <= 32'(map_s(dl_l));

		hz_s2     <= hz_s1;
		clcd_m_s2 <= 64'(cl_s1) * 64'(cd_s1);
		clsd_m_s2 <= 64'(cl_s1) * 64'(sd_s1);
		srsl_s2   <= 64'(sr_s1) * 64'(sl_s1);
		crsl_s2   <= 64'(cr_s1) * 64'(sl_s1);
		cr_s2     <= cr_s1;
		sr_s2     <= sr_s1;

		hz_s3   <= hz_s2;
		clcd_s3 <= 32'((clcd_m_s2 + HALF30) >>> 30);
		px_s3   <= 32'((clsd_m_s2 + HALF30) >>> 30);
		cr_s3   <= cr_s2;
		sr_s3   <= sr_s2;
		srsl_s3 <= srsl_s2;
		crsl_s3 <= crsl_s2;

		hz_s4   <= hz_s3;
		crc_s4  <= 64'(cr_s3) * 64'(clcd_s3);
		src_s4  <= 64'(sr_s3) * 64'(clcd_s3);
		rpx_s4  <= 64'(rad) * 64'(px_s3);
		srsl_s4 <= srsl_s3;
		crsl_s4 <= crsl_s3;

		hz_s5  <= hz_s4;
		vis_s5 <= (srsl_s4 + crc_s4) >= 0;
		py_s5  <= 33'((crsl_s4 - src_s4 + HALF30) >>> 30);
		ex_s5  <= 32'(clamp64((rpx_s4 + HALF22) >>> 22, XY_LIMIT));

		hz_s6  <= hz_s5;
		vis_s6 <= vis_s5;
		ex_s6  <= ex_s5;
		rpy_s6 <= 64'(rad) * 64'(py_s5);

		height_z <= hz_s6;
		visible  <= vis_s6;
		east_x   <= vis_s6 ? ex_s6 : 32'sd0;
		north_y  <= vis_s6 ? 32'(clamp64((rpy_s6 + HALF22) >>> 22, XY_LIMIT)) : 32'sd0;
	end
endmodule

/* rtl/orthographic_forward_projection.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// orthographic_forward_projection
// spherical orthographic projection of points onto a reference tangent plane
// done follows start through the cordic cell chain and then the multiply
// pipeline; one request accepted every cycle, busy stays low; the receiver
// cannot stall; asynchronous reset clears the pipeline valids and loads the
// register reset values
// ----------------------------------------------------------------------------
module orthographic_forward_projection #(
	parameter int CORDIC_STAGES = ofp_pkg::CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] lat,
	input  logic signed [31:0] lon,
	input  logic signed [25:0] alt,
	output logic               done,
	output logic signed [31:0] east_x,
	output logic signed [31:0] north_y,
	output logic signed [26:0] height_z,
	output logic               visible,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import ofp_pkg::*;

	logic [31:0] ref_lat_q, ref_lon_q;
	logic [25:0] ref_alt_q;
	logic [22:0] radius_q;
	logic        wr;
	logic        acc;
	logic [31:0] dl;

	assign pready = 1'b1;
	assign busy   = 1'b0;
	assign wr     = psel && penable && pwrite && pready;
	assign acc    = start && !busy;
	assign dl     = lon - ref_lon_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_lat_q <= '0;
			ref_lon_q <= '0;
			ref_alt_q <= '0;
			radius_q  <= RADIUS_RST;
		end else if (wr) begin
			case (paddr[3:2])
				REG_REF_LAT: ref_lat_q <= pwdata;
				REG_REF_LON: ref_lon_q <= pwdata;
				REG_REF_ALT: ref_alt_q <= pwdata[25:0];
				REG_RADIUS:  radius_q  <= pwdata[22:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_REF_LAT: prdata = ref_lat_q;
			REG_REF_LON: prdata = ref_lon_q;
			REG_REF_ALT: prdata = {{6{ref_alt_q[25]}}, ref_alt_q};
			REG_RADIUS:  prdata = {9'd0, radius_q};
			default:     prdata = '0;
		endcase
	end

	function automatic ofp_lane_t seed(input logic [31:0] a);
		ofp_lane_t l;
		l.x    = CORDIC_GAIN;
		l.y    = '0;
		l.z    = $signed({2'b00, a[29:0]});
		l.quad = a[31:30];
		return l;
	endfunction

	ofp_lane_t lat_c [0:CORDIC_STAGES];
	ofp_lane_t ref_c [0:CORDIC_STAGES];
	ofp_lane_t dl_c  [0:CORDIC_STAGES];
	logic [CORDIC_STAGES:0] vld_c;
	logic signed [26:0] hz_c [0:CORDIC_STAGES];

	assign lat_c[0] = seed(lat);
	assign ref_c[0] = seed(ref_lat_q);
	assign dl_c[0]  = seed(dl);
	assign vld_c[0] = acc;
	assign hz_c[0]  = 27'(alt) - 27'($signed(ref_alt_q));

	for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
		ofp_cordic_cell #(.STAGE(g)) u_lat (.clk(clk), .d(lat_c[g]), .q(lat_c[g+1]));
		ofp_cordic_cell #(.STAGE(g)) u_ref (.clk(clk), .d(ref_c[g]), .q(ref_c[g+1]));
		ofp_cordic_cell #(.STAGE(g)) u_dl  (.clk(clk), .d(dl_c[g]),  .q(dl_c[g+1]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				vld_c[g+1] <= 1'b0;
			else
				vld_c[g+1] <= vld_c[g];
		end

		always_ff @(posedge clk) begin
			hz_c[g+1] <= hz_c[g];
		end
	end

	ofp_post u_post (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_c[CORDIC_STAGES]),
		.in_hz    (hz_c[CORDIC_STAGES]),
		.lat_l    (lat_c[CORDIC_STAGES]),
		.ref_l    (ref_c[CORDIC_STAGES]),
		.dl_l     (dl_c[CORDIC_STAGES]),
		.radius   (radius_q),
		.done     (done),
		.east_x   (east_x),
		.north_y  (north_y),
		.height_z (height_z),
		.visible  (visible)
	);
endmodule
